>>> rtl/lrpm_pkg.sv
// Shared types, constants and table functions for the LED rule priority mixer.
// Used by lrpm_mix_unit and led_rule_priority_mixer_top; depends on nothing.
package lrpm_pkg;

	// Default sizes handed to the top level.
	localparam int NODES_DEF           = 4;
	localparam int LAYERS_DEF          = 2;
	localparam int RULES_PER_LAYER_DEF = 8;
	localparam int COLOR_CHANNELS_DEF  = 3;

	localparam int VALUE_W   = 16;
	localparam int RULE_W    = 8;
	localparam int WORD_W    = 64;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int KEYS_W    = 5;
	localparam int BREATH_W  = 10;
	localparam int TRIG_W    = 6;

	// Rule byte fields.
	localparam int RULE_INV_BIT = 7;
	localparam int RULE_MIN_BIT = 6;

	localparam logic [VALUE_W-1:0] FULL = 16'hffff;

	// Trigger codes.
	localparam logic [TRIG_W-1:0] TRIG_CONST  = 6'd0;
	localparam logic [TRIG_W-1:0] TRIG_KEY_LO = 6'd1;
	localparam logic [TRIG_W-1:0] TRIG_KEY_HI = 6'd5;
	localparam logic [TRIG_W-1:0] TRIG_USB    = 6'd6;
	localparam logic [TRIG_W-1:0] TRIG_BREATH = 6'd7;

	localparam logic [WORD_W-1:0] RULE_RESET [NUM_REGS] = '{
		64'h4001, 64'h0, 64'h4002, 64'h0,
		64'h40040307, 64'h4006, 64'h40040507, 64'h4006
	};

	localparam logic [VALUE_W-1:0] CONST_COLOUR [4][4][3] = '{
		'{'{16'h3ff, 16'h0, 16'h0}, '{16'h0, 16'h3ff, 16'h0},
		  '{16'h0, 16'h0, 16'h3ff}, '{16'h3ff, 16'h3ff, 16'h0}},
		'{'{16'h0, 16'h0, 16'h3ff}, '{16'h0, 16'h0, 16'h0},
		  '{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h3ff}},
		'{'{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0},
		  '{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}},
		'{'{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0},
		  '{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}}
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RULE,
		ST_FOLD,
		ST_EMIT
	} lrpm_state_t;

	typedef struct packed {
		logic inv;
		logic min;
	} lrpm_mix_ctrl_t;

	// Constant colour for a layer, LED and channel; channel code 3 has no entry.
	function automatic logic [VALUE_W-1:0] const_colour(input logic [1:0] layer,
			input logic [1:0] led, input logic [1:0] chan);
		logic [VALUE_W-1:0] v;
		v = '0;
		if (chan != 2'd3) begin
			v = CONST_COLOUR[layer][led][chan];
		end
		return v;
	endfunction

	// Fixed wiring of nodes to LEDs.
	function automatic logic [1:0] node_led(input logic [1:0] node);
		logic [1:0] led;
		unique case (node)
			2'd0: led = 2'd1;
			2'd1: led = 2'd2;
			2'd2: led = 2'd0;
			2'd3: led = 2'd3;
			default: led = 2'd0;
		endcase
		return led;
	endfunction

endpackage

>>> rtl/lrpm_mix_unit.sv
// Shared min/max mixing unit with optional inversion of the incoming value.
// Depends on lrpm_pkg for the value width and the control struct.
module lrpm_mix_unit (
	input  logic [lrpm_pkg::VALUE_W-1:0] a,
	input  logic [lrpm_pkg::VALUE_W-1:0] b,
	input  lrpm_pkg::lrpm_mix_ctrl_t     ctrl,
	output logic [lrpm_pkg::VALUE_W-1:0] y
);

	logic [lrpm_pkg::VALUE_W-1:0] b_eff;
	logic                         b_lt;
	logic                         take_b;

	always_comb begin
		b_eff  = ctrl.inv ? ~b : b;
		b_lt   = b_eff < a;
		// Max keeps the new value on a tie, min keeps the old one.
		take_b = ctrl.min ? b_lt : !b_lt;
		y      = take_b ? b_eff : a;
	end

endmodule

>>> rtl/led_rule_priority_mixer_top.sv
// LED rule priority mixer, top level: rule registers, sequencer and datapath.
// Depends on lrpm_pkg and instantiates lrpm_mix_unit.
//
// A frame item is taken on start while busy is low; the block then walks the rules of
// every node, highest node first, and puts out one result per node, each on the result
// ports for exactly one cycle with strobe high; last marks the node 0 result. The
// receiver cannot stall, so results must be taken as they appear. All mixing goes
// through one min/max unit, one colour channel per cycle: each layer's rules are walked
// over every channel, then the layer is folded into the node value. A layer walks rules
// up to and including its first constant-trigger rule, at most RULES_PER_LAYER. Results
// of one frame are spaced by the work of one node. Rule registers are written through
// wr_en, wr_index and wr_data; the user must write them only while busy is low, as the
// block itself does not enforce it.
module led_rule_priority_mixer_top #(
	parameter int NODES           = lrpm_pkg::NODES_DEF,
	parameter int LAYERS          = lrpm_pkg::LAYERS_DEF,
	parameter int RULES_PER_LAYER = lrpm_pkg::RULES_PER_LAYER_DEF,
	parameter int COLOR_CHANNELS  = lrpm_pkg::COLOR_CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [lrpm_pkg::KEYS_W-1:0]      key_bits,
	input  logic                             usb_link,
	input  logic [lrpm_pkg::BREATH_W-1:0]    breath_level,
	input  logic                             wr_en,
	input  logic [lrpm_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [lrpm_pkg::WORD_W-1:0]      wr_data,
	output logic                             strobe,
	output logic [1:0]                       led_number,
	output logic [lrpm_pkg::VALUE_W-1:0]     value_0,
	output logic [lrpm_pkg::VALUE_W-1:0]     value_1,
	output logic [lrpm_pkg::VALUE_W-1:0]     value_2,
	output logic                             last
);

	localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int RIDX_W  = (RULES_PER_LAYER > 1) ? $clog2(RULES_PER_LAYER) : 1;
	localparam int CH_W    = (COLOR_CHANNELS > 1) ? $clog2(COLOR_CHANNELS) : 1;
	localparam int VW      = lrpm_pkg::VALUE_W;

	localparam logic [NODE_W-1:0]  NODE_TOP   = NODE_W'(NODES - 1);
	localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(LAYERS - 1);
	localparam logic [RIDX_W-1:0]  RULE_LAST  = RIDX_W'(RULES_PER_LAYER - 1);
	localparam logic [CH_W-1:0]    CH_LAST    = CH_W'(COLOR_CHANNELS - 1);

	lrpm_pkg::lrpm_state_t state_q, state_d;

	logic [lrpm_pkg::WORD_W-1:0]   rules_q [lrpm_pkg::NUM_REGS];
	logic [NODE_W-1:0]             node_q;
	logic [LAYER_W-1:0]            layer_q;
	logic [RIDX_W-1:0]             rule_q;
	logic [CH_W-1:0]               ch_q;
	logic                          first_min_q;
	logic [lrpm_pkg::KEYS_W-1:0]   keys_q;
	logic                          usb_q;
	logic [lrpm_pkg::BREATH_W-1:0] breath_q;
	logic [VW-1:0]                 lay_q [COLOR_CHANNELS];
	logic [VW-1:0]                 acc_q [COLOR_CHANNELS];

	logic                          strobe_q;
	logic [1:0]                    led_q;
	logic [VW-1:0]                 val0_q, val1_q, val2_q;
	logic                          last_q;

	logic [2:0]                    node_x;
	logic [1:0]                    layer_x;
	logic                          reg_exists;
	logic [lrpm_pkg::REG_IDX_W-1:0] reg_idx;
	logic [lrpm_pkg::WORD_W-1:0]   rule_word;
	logic [lrpm_pkg::RULE_W-1:0]   rule_byte;
	logic [lrpm_pkg::TRIG_W-1:0]   trig_id;
	logic [VW-1:0]                 trig_val;
	logic [1:0]                    led;
	logic [1:0]                    const_ch;
	logic [VW-1:0]                 mix_a, mix_b, mix_y;
	lrpm_pkg::lrpm_mix_ctrl_t      mix_ctrl;
	logic                          ch_last;
	logic                          rule_stop;
	logic                          accept;
	logic [VW-1:0]                 out_vals [3];

	assign accept = start && !busy;
	assign busy   = (state_q != lrpm_pkg::ST_IDLE);

	// Rule byte of the current node, layer and rule; a node or layer without a register
	// reads as zero.
	always_comb begin
		node_x     = 3'(node_q);
		layer_x    = 2'(layer_q);
		reg_exists = !node_x[2] && !layer_x[1];
		reg_idx    = {node_x[1:0], layer_x[0]};
		rule_word  = reg_exists ? rules_q[reg_idx] : '0;
		rule_byte  = rule_word[lrpm_pkg::RULE_W*rule_q +: lrpm_pkg::RULE_W];
		trig_id    = rule_byte[lrpm_pkg::TRIG_W-1:0];
		led        = lrpm_pkg::node_led(node_x[1:0]);
		ch_last    = (ch_q == CH_LAST);
		rule_stop  = (trig_id == lrpm_pkg::TRIG_CONST) || (rule_q == RULE_LAST);
	end

	// Trigger value for the channel in hand.
	always_comb begin
		const_ch = (COLOR_CHANNELS > 3) ? 2'd0 : 2'(ch_q);
		priority if (trig_id == lrpm_pkg::TRIG_CONST) begin
			trig_val = lrpm_pkg::const_colour(layer_x, led, const_ch);
		end else if (trig_id >= lrpm_pkg::TRIG_KEY_LO && trig_id <= lrpm_pkg::TRIG_KEY_HI) begin
			trig_val = keys_q[3'(trig_id - lrpm_pkg::TRIG_KEY_LO)] ? lrpm_pkg::FULL : '0;
		end else if (trig_id == lrpm_pkg::TRIG_USB) begin
			trig_val = usb_q ? lrpm_pkg::FULL : '0;
		end else if (trig_id == lrpm_pkg::TRIG_BREATH) begin
			trig_val = VW'(breath_q);
		end else begin
			trig_val = '0;
		end
	end

	// Operand select for the shared mix unit: rule walk or layer fold.
	always_comb begin
		if (state_q == lrpm_pkg::ST_FOLD) begin
			mix_a        = acc_q[ch_q];
			mix_b        = lay_q[ch_q];
			mix_ctrl.inv = 1'b0;
			mix_ctrl.min = first_min_q;
		end else begin
			mix_a        = lay_q[ch_q];
			mix_b        = trig_val;
			mix_ctrl.inv = rule_byte[lrpm_pkg::RULE_INV_BIT];
			mix_ctrl.min = rule_byte[lrpm_pkg::RULE_MIN_BIT];
		end
	end

	lrpm_mix_unit u_mix (
		.a    (mix_a),
		.b    (mix_b),
		.ctrl (mix_ctrl),
		.y    (mix_y)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrpm_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lrpm_pkg::ST_INIT;
				end
			end
			lrpm_pkg::ST_INIT: begin
				state_d = lrpm_pkg::ST_RULE;
			end
			lrpm_pkg::ST_RULE: begin
				if (ch_last && rule_stop) begin
					state_d = lrpm_pkg::ST_FOLD;
				end
			end
			lrpm_pkg::ST_FOLD: begin
				if (ch_last) begin
					state_d = (layer_q == LAYER_LAST) ? lrpm_pkg::ST_EMIT : lrpm_pkg::ST_INIT;
				end
			end
			lrpm_pkg::ST_EMIT: begin
				state_d = (node_q == '0) ? lrpm_pkg::ST_IDLE : lrpm_pkg::ST_INIT;
			end
			default: state_d = lrpm_pkg::ST_IDLE;
		endcase
	end

	// Loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q      <= '0;
			layer_q     <= '0;
			rule_q      <= '0;
			ch_q        <= '0;
			first_min_q <= 1'b0;
		end else begin
			unique case (state_q)
				lrpm_pkg::ST_IDLE: begin
					if (accept) begin
						node_q  <= NODE_TOP;
						layer_q <= '0;
					end
				end
				lrpm_pkg::ST_INIT: begin
					// rule_q is zero here, so this is the layer's first rule byte
					first_min_q <= rule_byte[lrpm_pkg::RULE_MIN_BIT];
					ch_q        <= '0;
				end
				lrpm_pkg::ST_RULE: begin
					if (ch_last) begin
						ch_q <= '0;
						if (!rule_stop) begin
							rule_q <= rule_q + 1'b1;
						end
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				lrpm_pkg::ST_FOLD: begin
					rule_q <= '0;
					if (ch_last) begin
						ch_q <= '0;
						if (layer_q != LAYER_LAST) begin
							layer_q <= layer_q + 1'b1;
						end
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				lrpm_pkg::ST_EMIT: begin
					layer_q <= '0;
					if (node_q != '0) begin
						node_q <= node_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Rule registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lrpm_pkg::NUM_REGS; i++) begin
				rules_q[i] <= lrpm_pkg::RULE_RESET[i];
			end
		end else if (wr_en) begin
			rules_q[wr_index] <= wr_data;
		end
	end

	// Item capture and channel accumulators.
	always_ff @(posedge clk) begin
		if (accept) begin
			keys_q   <= key_bits;
			usb_q    <= usb_link;
			breath_q <= breath_level;
		end
		unique case (state_q)
			lrpm_pkg::ST_INIT: begin
				for (int c = 0; c < COLOR_CHANNELS; c++) begin
					lay_q[c] <= rule_byte[lrpm_pkg::RULE_MIN_BIT] ? lrpm_pkg::FULL : '0;
				end
			end
			lrpm_pkg::ST_RULE: begin
				lay_q[ch_q] <= mix_y;
			end
			lrpm_pkg::ST_FOLD: begin
				// layer 0 seeds the node value, later layers fold into it
				acc_q[ch_q] <= (layer_q == '0) ? lay_q[ch_q] : mix_y;
			end
			default: ;
		endcase
	end

	for (genvar k = 0; k < 3; k++) begin : g_out
		if (k < COLOR_CHANNELS) begin : g_used
			assign out_vals[k] = acc_q[k];
		end else begin : g_unused
			assign out_vals[k] = '0;
		end
	end

	// Result register: one cycle per node.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == lrpm_pkg::ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lrpm_pkg::ST_EMIT) begin
			led_q  <= led;
			val0_q <= out_vals[0];
			val1_q <= out_vals[1];
			val2_q <= out_vals[2];
			last_q <= (node_q == '0);
		end
	end

	assign strobe     = strobe_q;
	assign led_number = led_q;
	assign value_0    = val0_q;
	assign value_1    = val1_q;
	assign value_2    = val2_q;
	assign last       = last_q;

	// The frame ends with the node 0 result.
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("frame ended without its last result");

	// Results of one frame never come in adjacent cycles.
	a_strobe_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back result strobes");

	a_last_led: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> led_number == lrpm_pkg::node_led(2'd0))
		else $error("last result not from node 0");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && node_q == NODE_TOP && layer_q == '0)
		else $error("item accepted without starting the walk");

	a_rule_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lrpm_pkg::ST_RULE |-> rule_q <= RULE_LAST && ch_q <= CH_LAST)
		else $error("rule or channel counter out of range");

endmodule
